FILE: hdl/ftf_pkg.sv
// Package for the FIFO frame table: sizes, entry and control types,
// request and status codes. No dependencies.
package ftf_pkg;

  localparam int FRAMES     = 64;
  localparam int PAGE_BITS  = 20;
  localparam int OWNER_BITS = 16;

  localparam int IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_BITS = $clog2(FRAMES + 1);
  localparam int OUT_CNT_BITS = 7;

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_LOOKUP = 3'd1,
    REQ_DELETE = 3'd2,
    REQ_PURGE  = 3'd3,
    REQ_VICTIM = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NOTFOUND = 2'd1,
    STS_FULL     = 2'd2,
    STS_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_SHIFT = 2'd2
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic [PAGE_BITS-1:0]  upage;
    logic [PAGE_BITS-1:0]  kpage;
    logic [OWNER_BITS-1:0] owner;
  } entry_t;

  typedef struct packed {
    cell_op_t            op;
    logic [IDX_BITS-1:0] wpos;
    logic                keep;
  } cell_ctl_t;

endpackage

FILE: hdl/frame_table_fifo_victim.sv
// Top level of the FIFO frame table: request sequencer, row of entry cells
// and result register. Depends on ftf_pkg and ftf_cell.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | in_valid/in_ready, in_req_type ...       | in
//  result  | out_valid/out_ready, out_status ...      | out
//
// Sequence: insert and unused codes go from accept through run to done; victim
// rotates one step; lookup, delete and purge make one full rotation of the
// cell chain, one entry examined at the head per cycle.
// Reset: synchronous, active low; clears the fill count and control, leaves
// entry payload as is (slots at or past the fill count are never read).
// Stalls: a finished result sits in the output register; a new request is
// accepted while it waits. The sequencer holds in its done state only if the
// output register is still occupied and out_ready is low.
module frame_table_fifo_victim (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     in_req_type,
  input  logic [ftf_pkg::PAGE_BITS-1:0]  in_user_page,
  input  logic [ftf_pkg::PAGE_BITS-1:0]  in_kernel_page,
  input  logic [ftf_pkg::OWNER_BITS-1:0] in_owner_id,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [ftf_pkg::PAGE_BITS-1:0]  out_found_user_page,
  output logic [ftf_pkg::PAGE_BITS-1:0]  out_found_kernel_page,
  output logic [ftf_pkg::OWNER_BITS-1:0] out_found_owner,
  output logic [6:0]                     out_removed_count,
  output logic [6:0]                     out_occupancy
);
  import ftf_pkg::*;

  // Sequencer state
  state_t              state_r, state_nxt;
  logic [2:0]          req_r;
  entry_t              key_r;          // item fields of the current transaction
  logic [CNT_BITS-1:0] count_r;        // entries held, packed from slot 0
  logic [CNT_BITS-1:0] steps_r;        // rotation steps left
  logic [CNT_BITS-1:0] removed_r;
  logic                found_r;
  logic                full_r;
  entry_t              found_r_entry;

  // Output register
  logic                out_valid_r;
  status_t             out_status_r;
  entry_t              out_entry_r;
  logic [OUT_CNT_BITS-1:0] out_removed_r;
  logic [OUT_CNT_BITS-1:0] out_occ_r;

  // Control decode
  logic      accept;
  logic      load_out;
  logic      step_en;
  logic      do_insert;
  logic      drop;
  logic      capture;
  logic      match_key;
  logic      match_owner;
  cell_ctl_t cell_ctl;
  status_t   status_now;

  entry_t    cell_q [FRAMES];
  entry_t    head;

  assign head   = cell_q[0];
  assign accept = in_valid && in_ready;

  // ------------------------------------------------------------------
  // Cell row
  // ------------------------------------------------------------------
  genvar gi;
  generate
    for (gi = 0; gi < FRAMES; gi++) begin : g_cell
      entry_t nbr;
      if (gi < FRAMES - 1) begin : g_mid
        assign nbr = cell_q[gi+1];
      end else begin : g_last
        assign nbr = '0;
      end
      ftf_cell u_cell (
        .clk       (clk),
        .cell_idx  (IDX_BITS'(gi)),
        .ctl       (cell_ctl),
        .nbr       (nbr),
        .head      (head),
        .new_entry (key_r),
        .data      (cell_q[gi])
      );
    end
  endgenerate

  // ------------------------------------------------------------------
  // Head compare: one entry examined per rotation step
  // ------------------------------------------------------------------
  assign match_owner = (head.owner == key_r.owner);
  assign match_key   = match_owner && (head.kpage == key_r.kpage);

  // ------------------------------------------------------------------
  // Next state
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (req_r == REQ_INSERT) begin
          state_nxt = ST_DONE;
        end else if (req_r == REQ_LOOKUP || req_r == REQ_DELETE ||
                     req_r == REQ_PURGE  || req_r == REQ_VICTIM) begin
          if (steps_r == '0) state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // Outputs of the sequencer
  // ------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    load_out  = 1'b0;
    step_en   = 1'b0;
    do_insert = 1'b0;
    drop      = 1'b0;
    capture   = 1'b0;
    cell_ctl  = '{op: CELL_HOLD, wpos: '0, keep: 1'b0};
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_RUN: begin
        if (req_r == REQ_INSERT) begin
          if (count_r < CNT_BITS'(FRAMES)) begin
            do_insert     = 1'b1;
            cell_ctl.op   = CELL_LOAD;
            cell_ctl.wpos = count_r[IDX_BITS-1:0];
          end
        end else if (steps_r != '0) begin
          step_en = 1'b1;
          case (req_r)
            REQ_LOOKUP: capture = match_key && !found_r;
            REQ_DELETE: begin
              capture = match_key && !found_r;
              drop    = capture;
            end
            REQ_PURGE:  drop = match_owner;
            REQ_VICTIM: begin
              capture = 1'b1;
              drop    = 1'b1;
            end
            default: ;
          endcase
          // rotate: head goes back to the tail unless dropped
          cell_ctl.op   = CELL_SHIFT;
          cell_ctl.keep = !drop;
          cell_ctl.wpos = IDX_BITS'(count_r - CNT_BITS'(1));
        end
      end
      ST_DONE: begin
        load_out = !out_valid_r || out_ready;
      end
      default: ;
    endcase
  end

  // Result status of the finished transaction
  always_comb begin
    case (req_r)
      REQ_INSERT: status_now = full_r ? STS_FULL : STS_OK;
      REQ_LOOKUP,
      REQ_DELETE: status_now = found_r ? STS_OK : STS_NOTFOUND;
      REQ_VICTIM: status_now = found_r ? STS_OK : STS_EMPTY;
      default:    status_now = STS_OK;
    endcase
  end

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      steps_r     <= '0;
      found_r     <= 1'b0;
      full_r      <= 1'b0;
      removed_r   <= '0;
      req_r       <= '0;
    end else begin
      state_r <= state_nxt;

      if (accept) begin
        req_r     <= in_req_type;
        found_r   <= 1'b0;
        full_r    <= 1'b0;
        removed_r <= '0;
        // victim needs one step, searches rotate the whole table;
        // inserts and unused codes never rotate
        if (in_req_type == REQ_VICTIM)
          steps_r <= (count_r != '0) ? CNT_BITS'(1) : '0;
        else if (in_req_type == REQ_LOOKUP || in_req_type == REQ_DELETE ||
                 in_req_type == REQ_PURGE)
          steps_r <= count_r;
        else
          steps_r <= '0;
      end

      if (state_r == ST_RUN && req_r == REQ_INSERT && !do_insert)
        full_r <= 1'b1;
      if (do_insert)
        count_r <= count_r + CNT_BITS'(1);

      if (step_en) begin
        steps_r <= steps_r - CNT_BITS'(1);
        if (capture) found_r <= 1'b1;
        if (drop) begin
          count_r   <= count_r - CNT_BITS'(1);
          removed_r <= removed_r + CNT_BITS'(1);
        end
      end

      if (load_out)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r.upage <= in_user_page;
      key_r.kpage <= in_kernel_page;
      key_r.owner <= in_owner_id;
    end
    if (capture)
      found_r_entry <= head;
    if (load_out) begin
      out_status_r  <= status_now;
      out_entry_r   <= found_r ? found_r_entry : '0;
      out_removed_r <= OUT_CNT_BITS'(removed_r);
      out_occ_r     <= OUT_CNT_BITS'(count_r);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_found_user_page   = out_entry_r.upage;
  assign out_found_kernel_page = out_entry_r.kpage;
  assign out_found_owner       = out_entry_r.owner;
  assign out_removed_count     = out_removed_r;
  assign out_occupancy         = out_occ_r;

endmodule

FILE: hdl/ftf_cell.sv
// One slot of the frame table chain: holds one entry and takes its upper
// neighbor, the head entry or a new entry. Depends on ftf_pkg.
module ftf_cell (
  input  logic               clk,
  input  logic [ftf_pkg::IDX_BITS-1:0] cell_idx,
  input  ftf_pkg::cell_ctl_t ctl,
  input  ftf_pkg::entry_t    nbr,
  input  ftf_pkg::entry_t    head,
  input  ftf_pkg::entry_t    new_entry,
  output ftf_pkg::entry_t    data
);
  import ftf_pkg::*;

  entry_t data_r;
  entry_t data_nxt;
  logic   at_wpos;

  assign at_wpos = (cell_idx == ctl.wpos);

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      CELL_LOAD: begin
        if (at_wpos) data_nxt = new_entry;
      end
      CELL_SHIFT: begin
        // recycle the head into the tail slot, everything else moves down
        data_nxt = (ctl.keep && at_wpos) ? head : nbr;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

FILE: hdl/ftf_checker.sv
// Port-level checks for the FIFO frame table, bound to the top level.
// Depends on ftf_pkg and frame_table_fifo_victim.
module ftf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [1:0]                     out_status,
  input logic [ftf_pkg::PAGE_BITS-1:0]  out_found_user_page,
  input logic [ftf_pkg::PAGE_BITS-1:0]  out_found_kernel_page,
  input logic [ftf_pkg::OWNER_BITS-1:0] out_found_owner,
  input logic [6:0]                     out_removed_count,
  input logic [6:0]                     out_occupancy
);
  import ftf_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_occupancy) && $stable(out_removed_count))
    else $error("result changed while stalled");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (FRAMES < 128) |-> out_occupancy <= 7'(FRAMES))
    else $error("occupancy above table size");

  a_full_nothing_removed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_FULL |->
      out_removed_count == '0 && out_found_user_page == '0 &&
      (FRAMES >= 128 || out_occupancy == 7'(FRAMES)))
    else $error("full insert changed the table");

  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STS_NOTFOUND || out_status == STS_EMPTY) |->
      out_removed_count == '0 && out_found_user_page == '0 &&
      out_found_kernel_page == '0 && out_found_owner == '0)
    else $error("miss reported data");

endmodule

bind frame_table_fifo_victim ftf_checker u_ftf_checker (.*);

FILE: test/frame_table_checker.sv
// Result checker for the FIFO frame table: watches both channels, keeps its own
// copy of the resident table and compares every result transaction.
// Depends on ftf_pkg for sizes, entry layout, request and status codes.
module frame_table_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [2:0]                     in_req_type,
  input  logic [ftf_pkg::PAGE_BITS-1:0]  in_user_page,
  input  logic [ftf_pkg::PAGE_BITS-1:0]  in_kernel_page,
  input  logic [ftf_pkg::OWNER_BITS-1:0] in_owner_id,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [1:0]                     out_status,
  input  logic [ftf_pkg::PAGE_BITS-1:0]  out_found_user_page,
  input  logic [ftf_pkg::PAGE_BITS-1:0]  out_found_kernel_page,
  input  logic [ftf_pkg::OWNER_BITS-1:0] out_found_owner,
  input  logic [6:0]                     out_removed_count,
  input  logic [6:0]                     out_occupancy,
  output int unsigned                    fail_count,
  output int unsigned                    pending_count,
  output int unsigned                    checked_count,
  output int unsigned                    full_count,
  output int unsigned                    empty_count,
  output int unsigned                    peak_occupancy
);
  import ftf_pkg::*;

  typedef struct packed {
    status_t               status;
    logic [PAGE_BITS-1:0]  user_page;
    logic [PAGE_BITS-1:0]  kernel_page;
    logic [OWNER_BITS-1:0] owner;
    logic [6:0]            removed;
    logic [6:0]            occupancy;
  } frame_result_t;

  entry_t        resident_frames[$];
  frame_result_t awaited_results[$];
  frame_result_t want_r;
  int unsigned   fails = 0;
  int unsigned   checked = 0;
  int unsigned   fulls = 0;
  int unsigned   empties = 0;
  int unsigned   peak = 0;

  // Apply one request to the shadow table, oldest entry at the front.
  function automatic frame_result_t predict_frame_request(
    input logic [2:0]            req,
    input logic [PAGE_BITS-1:0]  upage,
    input logic [PAGE_BITS-1:0]  kpage,
    input logic [OWNER_BITS-1:0] owner
  );
    frame_result_t r;
    entry_t        e;
    int            idx;
    int            removed;
    int            occ;
    r = '0;
    r.status = STS_OK;
    idx = -1;
    removed = 0;
    case (req)
      REQ_INSERT: begin
        if (resident_frames.size() >= FRAMES) begin
          r.status = STS_FULL;
        end else begin
          e.upage = upage;
          e.kpage = kpage;
          e.owner = owner;
          resident_frames.push_back(e);
        end
      end
      REQ_LOOKUP, REQ_DELETE: begin
        foreach (resident_frames[i]) begin
          if (idx < 0 && resident_frames[i].kpage == kpage && resident_frames[i].owner == owner)
            idx = i;
        end
        if (idx < 0) begin
          r.status = STS_NOTFOUND;
        end else begin
          r.user_page = resident_frames[idx].upage;
          r.kernel_page = resident_frames[idx].kpage;
          r.owner = resident_frames[idx].owner;
          if (req == REQ_DELETE) begin
            resident_frames.delete(idx);
            removed = 1;
          end
        end
      end
      REQ_PURGE: begin
        idx = 0;
        while (idx < resident_frames.size()) begin
          if (resident_frames[idx].owner == owner) begin
            resident_frames.delete(idx);
            removed++;
          end else begin
            idx++;
          end
        end
      end
      REQ_VICTIM: begin
        if (resident_frames.size() == 0) begin
          r.status = STS_EMPTY;
        end else begin
          e = resident_frames.pop_front();
          r.user_page = e.upage;
          r.kernel_page = e.kpage;
          r.owner = e.owner;
          removed = 1;
        end
      end
      default: ;
    endcase
    occ = resident_frames.size();
    r.removed = removed[6:0];
    r.occupancy = occ[6:0];
    return r;
  endfunction

  task automatic compare_field(input string fname, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (got_v !== want_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      resident_frames.delete();
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          fails++;
          $display("%0t: result with none expected, status %0h occupancy %0h",
                   $time, out_status, out_occupancy);
        end else begin
          want_r = awaited_results.pop_front();
          checked++;
          compare_field("status", 32'(want_r.status), 32'(out_status));
          compare_field("found_user_page", 32'(want_r.user_page), 32'(out_found_user_page));
          compare_field("found_kernel_page", 32'(want_r.kernel_page),
                        32'(out_found_kernel_page));
          compare_field("found_owner", 32'(want_r.owner), 32'(out_found_owner));
          compare_field("removed_count", 32'(want_r.removed), 32'(out_removed_count));
          compare_field("occupancy", 32'(want_r.occupancy), 32'(out_occupancy));
        end
      end
      if (in_valid && in_ready) begin
        want_r = predict_frame_request(in_req_type, in_user_page, in_kernel_page, in_owner_id);
        if (want_r.status == STS_FULL) fulls++;
        if (want_r.status == STS_EMPTY) empties++;
        if (resident_frames.size() > peak) peak = resident_frames.size();
        awaited_results.push_back(want_r);
      end
    end
    fail_count <= fails;
    pending_count <= awaited_results.size();
    checked_count <= checked;
    full_count <= fulls;
    empty_count <= empties;
    peak_occupancy <= peak;
  end

endmodule

FILE: test/frame_table_fifo_victim_tb.sv
// Testbench top for the FIFO frame table: clock, reset, request stimulus and
// result back-pressure, with the verdict. Depends on ftf_pkg, the block and
// frame_table_checker, which predicts and compares every result.
module frame_table_fifo_victim_tb;
  import ftf_pkg::*;

  // Request codes past the victim pop; the block must ignore them.
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
  localparam int         PHASES = 8;
  localparam int         PHASE_ITEMS = 100;
  localparam int         TAIL_CYCLES = 80;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [2:0]            in_req_type;
  logic [PAGE_BITS-1:0]  in_user_page;
  logic [PAGE_BITS-1:0]  in_kernel_page;
  logic [OWNER_BITS-1:0] in_owner_id;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            out_status;
  logic [PAGE_BITS-1:0]  out_found_user_page;
  logic [PAGE_BITS-1:0]  out_found_kernel_page;
  logic [OWNER_BITS-1:0] out_found_owner;
  logic [6:0]            out_removed_count;
  logic [6:0]            out_occupancy;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned full_count;
  int unsigned empty_count;
  int unsigned peak_occupancy;

  // Sender pacing: transactions per burst left, and whether gaps are off.
  int burst_left = 0;
  bit quiet_phase = 1'b0;

  // Receiver stall pattern: current mode and cycles left in it.
  int stall_mode = 0;
  int mode_left = 0;
  int stall_tick = 0;

  // Small key pools so that lookups, deletes and purges hit often.
  logic [PAGE_BITS-1:0]  kpage_pool[8];
  logic [OWNER_BITS-1:0] owner_pool[4];

  frame_table_fifo_victim uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_type          (in_req_type),
    .in_user_page         (in_user_page),
    .in_kernel_page       (in_kernel_page),
    .in_owner_id          (in_owner_id),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_found_user_page  (out_found_user_page),
    .out_found_kernel_page(out_found_kernel_page),
    .out_found_owner      (out_found_owner),
    .out_removed_count    (out_removed_count),
    .out_occupancy        (out_occupancy)
  );

  frame_table_checker table_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_type          (in_req_type),
    .in_user_page         (in_user_page),
    .in_kernel_page       (in_kernel_page),
    .in_owner_id          (in_owner_id),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_found_user_page  (out_found_user_page),
    .out_found_kernel_page(out_found_kernel_page),
    .out_found_owner      (out_found_owner),
    .out_removed_count    (out_removed_count),
    .out_occupancy        (out_occupancy),
    .fail_count           (fail_count),
    .pending_count        (pending_count),
    .checked_count        (checked_count),
    .full_count           (full_count),
    .empty_count          (empty_count),
    .peak_occupancy       (peak_occupancy)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Back-pressure: switch between always ready, light stalls, heavy random
  // stalls and a periodic pattern, each held for a random stretch.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    stall_tick++;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 1) != 0);
      default: out_ready <= (stall_tick % 7 >= 3);
    endcase
  end

  // Drive one request transaction and hold it until accepted. A new burst
  // may start with an idle gap; drop valid only when the gap is non-empty,
  // so valid is never lowered and raised in the same step.
  task automatic send_request(input logic [2:0] req, input logic [PAGE_BITS-1:0] upage,
                              input logic [PAGE_BITS-1:0] kpage,
                              input logic [OWNER_BITS-1:0] owner);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (quiet_phase) gap = 0;
      else if ($urandom_range(0, 7) == 0) gap = $urandom_range(0, 70);
      else gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req_type <= req;
    in_user_page <= upage;
    in_kernel_page <= kpage;
    in_owner_id <= owner;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [PAGE_BITS-1:0] pick_kpage();
    logic [31:0] r;
    r = $urandom();
    if ($urandom_range(0, 9) < 8) r[PAGE_BITS-1:0] = kpage_pool[$urandom_range(0, 7)];
    return r[PAGE_BITS-1:0];
  endfunction

  function automatic logic [OWNER_BITS-1:0] pick_owner();
    logic [31:0] r;
    r = $urandom();
    if ($urandom_range(0, 9) < 8) r[OWNER_BITS-1:0] = owner_pool[$urandom_range(0, 3)];
    return r[OWNER_BITS-1:0];
  endfunction

  // One random request. Fill phases lean on inserts so the table runs into
  // full; drain phases lean on deletes, purges and victim pops down to empty.
  task automatic random_request(input bit filling);
    int          roll;
    logic [2:0]  req;
    logic [31:0] upage;
    roll = $urandom_range(0, 99);
    upage = $urandom();
    if (filling) begin
      if (roll < 88) req = REQ_INSERT;
      else if (roll < 94) req = REQ_LOOKUP;
      else if (roll < 96) req = REQ_DELETE;
      else if (roll < 97) req = REQ_PURGE;
      else if (roll < 99) req = REQ_VICTIM;
      else req = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    end else begin
      if (roll < 22) req = REQ_INSERT;
      else if (roll < 42) req = REQ_LOOKUP;
      else if (roll < 64) req = REQ_DELETE;
      else if (roll < 70) req = REQ_PURGE;
      else if (roll < 97) req = REQ_VICTIM;
      else req = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    end
    send_request(req, upage[PAGE_BITS-1:0], pick_kpage(), pick_owner());
  endtask

  task automatic refresh_pools();
    logic [31:0] r;
    foreach (kpage_pool[i]) begin
      r = $urandom();
      kpage_pool[i] = r[PAGE_BITS-1:0];
    end
    foreach (owner_pool[i]) begin
      r = $urandom();
      owner_pool[i] = r[OWNER_BITS-1:0];
    end
  endtask

  initial begin
    logic [PAGE_BITS-1:0]  pmax;
    logic [OWNER_BITS-1:0] omax;
    logic [PAGE_BITS-1:0]  ka;
    logic [OWNER_BITS-1:0] oa;
    logic [OWNER_BITS-1:0] ob;
    pmax = '1;
    omax = '1;
    ka = 20'h5A3C1;
    oa = 16'h0F0F;
    ob = 16'hF0F0;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= REQ_INSERT;
    in_user_page <= '0;
    in_kernel_page <= '0;
    in_owner_id <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: pop, lookup and delete miss, purge removes nothing.
    send_request(REQ_VICTIM, '0, '0, '0);
    send_request(REQ_LOOKUP, '0, '0, '0);
    send_request(REQ_DELETE, pmax, pmax, omax);
    send_request(REQ_PURGE, '0, '0, '0);
    // Unused codes with every payload bit set: ignored, table untouched.
    for (int c = REQ_UNUSED_LO; c <= REQ_UNUSED_HI; c++)
      send_request(3'(c), pmax, pmax, omax);
    // Field extremes, then a duplicate key pair with distinct user pages.
    send_request(REQ_INSERT, '0, '0, '0);
    send_request(REQ_INSERT, pmax, pmax, omax);
    send_request(REQ_INSERT, 20'h11111, ka, oa);
    send_request(REQ_INSERT, 20'h22222, ka, oa);
    send_request(REQ_LOOKUP, '0, ka, oa);
    send_request(REQ_LOOKUP, '0, ka, ob);
    send_request(REQ_DELETE, '0, ka, oa);
    send_request(REQ_LOOKUP, '0, ka, oa);
    send_request(REQ_LOOKUP, '0, pmax, omax);
    send_request(REQ_INSERT, 20'h33333, 20'h00042, oa);
    send_request(REQ_PURGE, '0, '0, oa);
    send_request(REQ_PURGE, '0, '0, oa);
    // Drain in FIFO order down to empty.
    send_request(REQ_VICTIM, '0, '0, '0);
    send_request(REQ_VICTIM, '0, '0, '0);
    send_request(REQ_VICTIM, '0, '0, '0);
    send_request(REQ_DELETE, '0, '0, '0);

    // Random part: alternate fill and drain phases with fresh key pools.
    // One drain phase runs the sender without gaps.
    for (int phase = 0; phase < PHASES; phase++) begin
      refresh_pools();
      quiet_phase = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++)
        random_request(phase % 2 == 0);
    end

    // Release the channel and let outstanding results drain.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d result transactions; table hit full %0d times, empty %0d times,",
             checked_count, full_count, empty_count);
    $display("peak occupancy %0d of %0d frames.", peak_occupancy, FRAMES);
    if (fail_count == 0) begin
      $display("frame_table_fifo_victim_tb OK");
    end else begin
      $display("frame_table_fifo_victim_tb NOT OK");
    end
    $finish;
  end

  // Watchdog: generous bound well past the slowest legal run.
  initial begin
    #10_000_000;
    $display("frame_table_fifo_victim_tb NOT OK");
    $finish;
  end

endmodule

FILE: files.f
hdl/ftf_pkg.sv
hdl/ftf_cell.sv
hdl/frame_table_fifo_victim.sv
hdl/ftf_checker.sv
test/frame_table_checker.sv
test/frame_table_fifo_victim_tb.sv
